[src/glpf_pkg.sv]
// ----------------------------------------------------------------------------
// glpf_pkg: shared definitions for the grid local peak finder
// Widths, limits, register indexes and the sequencer state codes.
// ----------------------------------------------------------------------------
package glpf_pkg;

	// Width of one grid value and of one line-store entry (both rows of a column).
	localparam int VALUE_W = 32;
	localparam int ENTRY_W = 2 * VALUE_W;

	// Width of the count registers and of the position counters.
	localparam int COUNT_W = 6;

	// Width of the row and column fields of a result word.
	localparam int INDEX_W = 5;

	// Largest grid accepted; counts above these are used as the limit.
	localparam int ROWS_MAX    = 32;
	localparam int COLUMNS_MAX = 32;

	// Configuration port geometry.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Register indexes, taken from the word address.
	typedef enum logic {
		REG_ROW_COUNT    = 1'b0,
		REG_COLUMN_COUNT = 1'b1
	} reg_index_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_RESOLVE = 5'b00010,
		S_FL_RD   = 5'b00100,
		S_FL_EV   = 5'b01000,
		S_FINISH  = 5'b10000
	} state_t;

endpackage

[src/glpf_ram.sv]
// ----------------------------------------------------------------------------
// glpf_ram: generic simple dual-port RAM
// One write port and one read port, read data registered and held while the
// read enable is low.
// ----------------------------------------------------------------------------
module glpf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/grid_local_peak_finder.sv]
// ----------------------------------------------------------------------------
// grid_local_peak_finder: four-neighbour local maximum detection
// Takes signed grid values in row-major order and emits the peaks in raster
// order, the last result of each grid carrying the end-of-matrix mark.
// ----------------------------------------------------------------------------
// Each value passes through the idle and resolve states: the cycle in which it
// is accepted issues a read of the line-store RAM for the right-hand neighbour,
// and the resolve state decides the cell above and writes the new value back.
// The final value of a grid is then followed by a flush of the last row, with a
// RAM read for each column right of the first, before the next word is taken.
// A result word that must be handed over while the output register is full and
// stalled holds the sequencer in its state until the register is free. The line
// store needs no clearing after reset: every grid starts afresh at row 0 and
// only reads entries that it wrote itself.
// ----------------------------------------------------------------------------
module grid_local_peak_finder #(
	parameter int MAX_COLUMNS = glpf_pkg::COLUMNS_MAX
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [glpf_pkg::ADDR_W-1:0]         paddr,
	input  logic [glpf_pkg::DATA_W-1:0]         pwdata,
	output logic [glpf_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	// Grid value channel.
	input  logic                                cell_valid,
	output logic                                cell_stall,
	input  logic signed [glpf_pkg::VALUE_W-1:0] cell_value,
	// Peak channel.
	output logic                                peak_valid,
	input  logic                                peak_stall,
	output logic [glpf_pkg::INDEX_W-1:0]        peak_row,
	output logic [glpf_pkg::INDEX_W-1:0]        peak_column,
	output logic                                is_peak,
	output logic                                end_of_matrix
);

	localparam int VW = glpf_pkg::VALUE_W;
	localparam int EW = glpf_pkg::ENTRY_W;
	localparam int CW = glpf_pkg::COUNT_W;
	localparam int IW = glpf_pkg::INDEX_W;
	localparam int AW = $clog2(MAX_COLUMNS);

	localparam logic [CW-1:0] ROW_CAP =
		(glpf_pkg::ROWS_MAX < (2 ** CW - 1)) ? CW'(glpf_pkg::ROWS_MAX) : {CW{1'b1}};
	localparam logic [CW-1:0] COL_CAP = CW'(MAX_COLUMNS);

	// Pick the even-row or odd-row half of a line-store entry.
	function automatic logic signed [VW-1:0] half_of(input logic [EW-1:0] e, input logic odd);
		logic signed [VW-1:0] h;
		h = odd ? signed'(e[EW-1:VW]) : signed'(e[VW-1:0]);
		return h;
	endfunction

	glpf_pkg::state_t state_q;

	logic [CW-1:0] row_count_q;
	logic [CW-1:0] column_count_q;
	logic [CW-1:0] row_pos_q;
	logic [CW-1:0] col_pos_q;
	logic [CW-1:0] flush_col_q;

	logic signed [VW-1:0] value_q;
	logic signed [VW-1:0] left_q;
	logic [EW-1:0]        win_q;

	logic          pend_valid_q;
	logic [IW-1:0] pend_row_q;
	logic [IW-1:0] pend_col_q;

	logic          out_valid_q;
	logic [IW-1:0] out_row_q;
	logic [IW-1:0] out_col_q;
	logic          out_peak_q;
	logic          out_last_q;

	logic [CW-1:0] rows_eff;
	logic [CW-1:0] cols_eff;
	logic          cfg_wr;
	logic          in_take;
	logic          out_free;

	logic [CW:0]   col_next;
	logic [CW:0]   flush_next;
	logic [CW:0]   flush_next2;
	logic          right_here;
	logic          flush_right;
	logic          last_item;
	logic          odd_row;

	logic signed [VW-1:0] res_center;
	logic signed [VW-1:0] res_up;
	logic signed [VW-1:0] res_right;
	logic                 res_out;
	logic                 res_commit;

	logic signed [VW-1:0] fl_center;
	logic signed [VW-1:0] fl_up;
	logic signed [VW-1:0] fl_right;
	logic                 fl_peak;
	logic                 fl_commit;
	logic                 fin_commit;

	logic          push;
	logic [IW-1:0] push_row;
	logic [IW-1:0] push_col;
	logic          push_peak;
	logic          push_last;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;
	logic [CW-1:0] row_above;

	// Line store: one entry per column, holding the even row and the odd row.
	glpf_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_COLUMNS)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Counts in use: zero counts as one, anything above the limit as the limit.
	always_comb begin
		rows_eff = row_count_q;
		if (row_count_q == '0) begin
			rows_eff = CW'(1);
		end else if (row_count_q > ROW_CAP) begin
			rows_eff = ROW_CAP;
		end
		cols_eff = column_count_q;
		if (column_count_q == '0) begin
			cols_eff = CW'(1);
		end else if (column_count_q > COL_CAP) begin
			cols_eff = COL_CAP;
		end
	end

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		if (glpf_pkg::reg_index_t'(paddr[glpf_pkg::ADDR_W-1]) == glpf_pkg::REG_COLUMN_COUNT) begin
			prdata = {{(glpf_pkg::DATA_W - CW){1'b0}}, column_count_q};
		end else begin
			prdata = {{(glpf_pkg::DATA_W - CW){1'b0}}, row_count_q};
		end
	end

	// Handshake helpers.
	assign cell_stall = (state_q != glpf_pkg::S_IDLE);
	assign in_take    = cell_valid & (state_q == glpf_pkg::S_IDLE);
	assign out_free   = ~out_valid_q | ~peak_stall;

	// Position arithmetic.
	assign col_next    = {1'b0, col_pos_q} + (CW + 1)'(1);
	assign flush_next  = {1'b0, flush_col_q} + (CW + 1)'(1);
	assign flush_next2 = {1'b0, flush_col_q} + (CW + 1)'(2);
	assign right_here  = col_next < {1'b0, cols_eff};
	assign flush_right = flush_next < {1'b0, cols_eff};
	assign last_item   = ({1'b0, row_pos_q} + (CW + 1)'(1) == {1'b0, rows_eff}) && !right_here;
	assign odd_row     = row_pos_q[0];
	assign row_above   = row_pos_q - CW'(1);

	// Decision on the cell above the value just taken.
	always_comb begin
		res_center = half_of(win_q, ~odd_row);
		res_up     = half_of(win_q, odd_row);
		res_right  = half_of(ram_rdata, ~odd_row);
		res_out    = (row_pos_q != '0)
			&& !((row_pos_q > CW'(1)) && (res_center < res_up))
			&& !(res_center < value_q)
			&& !((col_pos_q != '0) && (res_center < left_q))
			&& !(right_here && (res_center < res_right));
		if (last_item) begin
			res_commit = (state_q == glpf_pkg::S_RESOLVE)
				&& !(res_out && pend_valid_q && !out_free);
		end else begin
			res_commit = (state_q == glpf_pkg::S_RESOLVE) && !(res_out && !out_free);
		end
	end

	// Decision on a cell of the last row during the flush.
	always_comb begin
		fl_center  = half_of(win_q, odd_row);
		fl_up      = half_of(win_q, ~odd_row);
		fl_right   = half_of(ram_rdata, odd_row);
		fl_peak    = !((row_pos_q != '0) && (fl_center < fl_up))
			&& !((flush_col_q != '0) && (fl_center < left_q))
			&& !(flush_right && (fl_center < fl_right));
		fl_commit  = (state_q == glpf_pkg::S_FL_EV) && !(fl_peak && pend_valid_q && !out_free);
		fin_commit = (state_q == glpf_pkg::S_FINISH) && out_free;
	end

	// RAM accesses: look ahead one column on accept and during the flush, write back on resolve.
	always_comb begin
		ram_we    = res_commit;
		ram_waddr = col_pos_q[AW-1:0];
		ram_wdata = odd_row ? {value_q, win_q[VW-1:0]} : {win_q[EW-1:VW], value_q};
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (in_take) begin
			ram_re    = 1'b1;
			ram_raddr = right_here ? col_next[AW-1:0] : '0;
		end else if (state_q == glpf_pkg::S_FL_RD) begin
			ram_re    = flush_right;
			ram_raddr = flush_next[AW-1:0];
		end else if (fl_commit) begin
			ram_re    = flush_next2 < {1'b0, cols_eff};
			ram_raddr = flush_next2[AW-1:0];
		end
	end

	// Result word handed to the output register this cycle.
	always_comb begin
		push      = 1'b0;
		push_row  = pend_row_q;
		push_col  = pend_col_q;
		push_peak = 1'b1;
		push_last = 1'b0;
		if (res_commit && res_out && !last_item) begin
			push     = 1'b1;
			push_row = row_above[IW-1:0];
			push_col = col_pos_q[IW-1:0];
		end else if (res_commit && res_out && pend_valid_q) begin
			push = 1'b1;
		end else if (fl_commit && fl_peak && pend_valid_q) begin
			push = 1'b1;
		end else if (fin_commit) begin
			push      = 1'b1;
			push_last = 1'b1;
			if (!pend_valid_q) begin
				push_row  = '0;
				push_col  = '0;
				push_peak = 1'b0;
			end
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= glpf_pkg::S_IDLE;
			row_count_q    <= CW'(1);
			column_count_q <= CW'(1);
			row_pos_q      <= '0;
			col_pos_q      <= '0;
			flush_col_q    <= '0;
			pend_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!peak_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				glpf_pkg::S_IDLE: begin
					if (in_take) begin
						state_q <= glpf_pkg::S_RESOLVE;
					end
				end
				glpf_pkg::S_RESOLVE: begin
					if (res_commit) begin
						if (last_item) begin
							if (res_out) begin
								pend_valid_q <= 1'b1;
							end
							flush_col_q <= '0;
							state_q     <= glpf_pkg::S_FL_RD;
						end else begin
							if (right_here) begin
								col_pos_q <= col_next[CW-1:0];
							end else begin
								col_pos_q <= '0;
								row_pos_q <= row_pos_q + CW'(1);
							end
							state_q <= glpf_pkg::S_IDLE;
						end
					end
				end
				glpf_pkg::S_FL_RD: begin
					state_q <= glpf_pkg::S_FL_EV;
				end
				glpf_pkg::S_FL_EV: begin
					if (fl_commit) begin
						if (fl_peak) begin
							pend_valid_q <= 1'b1;
						end
						if (flush_right) begin
							flush_col_q <= flush_next[CW-1:0];
						end else begin
							state_q <= glpf_pkg::S_FINISH;
						end
					end
				end
				glpf_pkg::S_FINISH: begin
					if (fin_commit) begin
						pend_valid_q <= 1'b0;
						row_pos_q    <= '0;
						col_pos_q    <= '0;
						state_q      <= glpf_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= glpf_pkg::S_IDLE;
				end
			endcase

			// Any register write restarts the grid.
			if (cfg_wr) begin
				if (glpf_pkg::reg_index_t'(paddr[glpf_pkg::ADDR_W-1]) == glpf_pkg::REG_ROW_COUNT) begin
					row_count_q <= pwdata[CW-1:0];
				end else begin
					column_count_q <= pwdata[CW-1:0];
				end
				row_pos_q <= '0;
				col_pos_q <= '0;
			end
		end
	end

	// Datapath registers: taken value, store window, pending peak, output word.
	always_ff @(posedge clk) begin
		if (in_take) begin
			value_q <= cell_value;
		end
		if (res_commit) begin
			win_q  <= (cols_eff == CW'(1)) ? ram_wdata : ram_rdata;
			left_q <= res_center;
			if (last_item && res_out) begin
				pend_row_q <= row_above[IW-1:0];
				pend_col_q <= col_pos_q[IW-1:0];
			end
		end
		if (fl_commit) begin
			win_q  <= ram_rdata;
			left_q <= fl_center;
			if (fl_peak) begin
				pend_row_q <= row_pos_q[IW-1:0];
				pend_col_q <= flush_col_q[IW-1:0];
			end
		end
		if (push) begin
			out_row_q  <= push_row;
			out_col_q  <= push_col;
			out_peak_q <= push_peak;
			out_last_q <= push_last;
		end
	end

	assign peak_valid    = out_valid_q;
	assign peak_row      = out_row_q;
	assign peak_column   = out_col_q;
	assign is_peak       = out_peak_q;
	assign end_of_matrix = out_last_q;

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for grid_local_peak_finder
// Streams signed grids through the value channel under random sender gaps
// and receiver stalls, keeps its own line store and position counters to work
// out the peak words that each accepted value should release, and compares
// every peak word that leaves the block with the oldest one still awaited.
// ----------------------------------------------------------------------------
module testbench;
	import glpf_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = COLUMNS_MAX + 16;
	localparam int RANDOM_CELLS  = 400;
	localparam int MAX_CELLS     = 128;

	// One peak word as it leaves the block.
	typedef struct packed {
		logic [INDEX_W-1:0] row;
		logic [INDEX_W-1:0] column;
		logic               hit;
		logic               grid_end;
	} peak_word_t;

	// Ways in which the receiver holds off peak words.
	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_BURSTS
	} stall_mode_t;

	// Kinds of grid content.
	typedef enum int {
		VALUES_TIED,
		VALUES_FULL,
		VALUES_EXTREME,
		VALUES_MIXED
	} value_mode_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      psel        = 1'b0;
	logic                      penable     = 1'b0;
	logic                      pwrite      = 1'b0;
	logic [ADDR_W-1:0]         paddr       = '0;
	logic [DATA_W-1:0]         pwdata      = '0;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;
	logic                      cell_valid  = 1'b0;
	logic                      cell_stall;
	logic signed [VALUE_W-1:0] cell_value  = '0;
	logic                      peak_valid;
	logic                      peak_stall  = 1'b0;
	logic [INDEX_W-1:0]        peak_row;
	logic [INDEX_W-1:0]        peak_column;
	logic                      is_peak;
	logic                      end_of_matrix;

	// Shadow of the block: count registers, two-row store and positions.
	logic [COUNT_W-1:0]        rows_reg    = 6'd1;
	logic [COUNT_W-1:0]        columns_reg = 6'd1;
	logic signed [VALUE_W-1:0] line_copy [0:2*COLUMNS_MAX-1];
	int                        row_pos     = 0;
	int                        col_pos     = 0;

	peak_word_t expected_peaks[$];
	int         error_count   = 0;
	int         cycle_count   = 0;
	int         burst_left    = 0;
	bit         sender_steady = 1'b0;

	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left  = 0;
	int          run_left   = 0;
	bit          stall_run  = 1'b0;

	grid_local_peak_finder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.cell_valid    (cell_valid),
		.cell_stall    (cell_stall),
		.cell_value    (cell_value),
		.peak_valid    (peak_valid),
		.peak_stall    (peak_stall),
		.peak_row      (peak_row),
		.peak_column   (peak_column),
		.is_peak       (is_peak),
		.end_of_matrix (end_of_matrix)
	);

	// Clock with a period of ten units.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A count of zero stands for one, and a count beyond the limit for the limit.
	function automatic int effective_count(logic [COUNT_W-1:0] raw, int limit);
		if (raw == 0) return 1;
		if (raw > limit) return limit;
		return int'(raw);
	endfunction

	function automatic logic signed [VALUE_W-1:0] held(int r, int c);
		return line_copy[(r % 2) * COLUMNS_MAX + (c % COLUMNS_MAX)];
	endfunction

	// A cell is a peak when no existing neighbour is greater than it.
	function automatic bit peak_at(int r, int c, int cols, bit has_down,
			logic signed [VALUE_W-1:0] down);
		logic signed [VALUE_W-1:0] v;
		v = held(r, c);
		if (r > 0 && v < held(r - 1, c)) return 1'b0;
		if (has_down && v < down) return 1'b0;
		if (c > 0 && v < held(r, c - 1)) return 1'b0;
		if (c + 1 < cols && v < held(r, c + 1)) return 1'b0;
		return 1'b1;
	endfunction

	function automatic peak_word_t make_word(int r, int c, bit hit, bit closes);
		peak_word_t w;
		w.row      = r[INDEX_W-1:0];
		w.column   = c[INDEX_W-1:0];
		w.hit      = hit;
		w.grid_end = closes;
		return w;
	endfunction

	// Any register write restarts the grid at its first cell.
	function automatic void note_register_write(reg_index_t idx, logic [DATA_W-1:0] data);
		if (idx == REG_ROW_COUNT) begin
			rows_reg = data[COUNT_W-1:0];
		end else begin
			columns_reg = data[COUNT_W-1:0];
		end
		row_pos = 0;
		col_pos = 0;
	endfunction

	// Work out the peak words that an accepted value releases.
	task automatic predict_peaks(logic signed [VALUE_W-1:0] v);
		int         rows, cols, r, c, found, j;
		bit         last_cell;
		peak_word_t w;
		rows  = effective_count(rows_reg, ROWS_MAX);
		cols  = effective_count(columns_reg, COLUMNS_MAX);
		r     = row_pos;
		c     = col_pos;
		found = 0;
		if (r >= rows || c >= cols) begin
			r = 0;
			c = 0;
		end
		last_cell = (r + 1 == rows) && (c + 1 == cols);
		// The cell above is settled by the value now arriving below it.
		if (r > 0 && peak_at(r - 1, c, cols, 1'b1, v)) begin
			expected_peaks.push_back(make_word(r - 1, c, 1'b1, 1'b0));
			found++;
		end
		line_copy[(r % 2) * COLUMNS_MAX + c] = v;
		if (last_cell) begin
			// The last row has no neighbours below it.
			for (j = 0; j < cols; j++) begin
				if (peak_at(r, j, cols, 1'b0, '0)) begin
					expected_peaks.push_back(make_word(r, j, 1'b1, 1'b0));
					found++;
				end
			end
			if (found == 0) begin
				expected_peaks.push_back(make_word(0, 0, 1'b0, 1'b1));
			end else begin
				w = expected_peaks.pop_back();
				w.grid_end = 1'b1;
				expected_peaks.push_back(w);
			end
			row_pos = 0;
			col_pos = 0;
		end else if (c + 1 >= cols) begin
			col_pos = 0;
			row_pos = r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endtask

	// Offer one grid value; the sender pauses between bursts unless held steady.
	task automatic send_cell(logic signed [VALUE_W-1:0] v);
		int gap;
		if (!sender_steady && burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
			if (gap > 0) begin
				cell_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0) burst_left--;
		cell_value <= v;
		cell_valid <= 1'b1;
		do @(posedge clk); while (cell_stall);
		predict_peaks(v);
	endtask

	// Wait until every awaited word has arrived and the block has gone quiet.
	task automatic settle();
		int waited;
		cell_valid <= 1'b0;
		waited = 0;
		while (expected_peaks.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_peaks.size() != 0) begin
			$display("%0t: %0d expected peak words never arrived", $time,
				expected_peaks.size());
			error_count++;
			expected_peaks.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, then the access cycle in which the register takes the data.
	task automatic write_register(reg_index_t idx, logic [COUNT_W-1:0] count);
		logic [DATA_W-1:0] data;
		data = $urandom();
		data[COUNT_W-1:0] = count;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		note_register_write(idx, data);
	endtask

	task automatic configure(logic [COUNT_W-1:0] rows, logic [COUNT_W-1:0] cols);
		settle();
		if ($urandom_range(0, 1) == 0) begin
			write_register(REG_ROW_COUNT, rows);
			write_register(REG_COLUMN_COUNT, cols);
		end else begin
			write_register(REG_COLUMN_COUNT, cols);
			write_register(REG_ROW_COUNT, rows);
		end
	endtask

	function automatic logic signed [VALUE_W-1:0] random_value(value_mode_t mode);
		value_mode_t pick;
		pick = mode;
		if (mode == VALUES_MIXED) pick = value_mode_t'($urandom_range(0, 2));
		case (pick)
			VALUES_TIED: begin
				return $signed($urandom_range(0, 6)) - 3;
			end
			VALUES_EXTREME: begin
				case ($urandom_range(0, 5))
					0: return 32'sh8000_0000;
					1: return 32'sh8000_0001;
					2: return 32'sh7FFF_FFFF;
					3: return 32'sh7FFF_FFFE;
					4: return 32'sh0000_0000;
					default: return -32'sd1;
				endcase
			end
			default: begin
				return $signed($urandom());
			end
		endcase
	endfunction

	// Mostly small counts, now and then the limit or a count that gets clamped.
	function automatic logic [COUNT_W-1:0] random_count();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) return $urandom_range(1, 6);
		if (pick < 75) return $urandom_range(7, 12);
		if (pick < 82) return 6'd0;
		if (pick < 90) return $urandom_range(33, 63);
		return 6'd32;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	// Compare each peak word taken from the block with the oldest one awaited.
	always @(posedge clk) begin : check_peaks
		peak_word_t want;
		if (arst_n && peak_valid && !peak_stall) begin
			if (expected_peaks.size() == 0) begin
				$display("%0t: unexpected peak word, expected none, got row %0d column %0d %0d %0d",
					$time, peak_row, peak_column, is_peak, end_of_matrix);
				error_count++;
			end else begin
				want = expected_peaks.pop_front();
				check_field("peak_row", want.row, peak_row);
				check_field("peak_column", want.column, peak_column);
				check_field("is_peak", want.hit, is_peak);
				check_field("end_of_matrix", want.grid_end, end_of_matrix);
			end
		end
	end

	// The receiver switches between several stall patterns of its own.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left  = $urandom_range(64, 256);
		end
		mode_left--;
		case (stall_mode)
			STALL_NONE: begin
				peak_stall <= 1'b0;
			end
			STALL_RANDOM: begin
				peak_stall <= ($urandom_range(0, 2) == 0);
			end
			STALL_PERIODIC: begin
				peak_stall <= (cycle_count % 3 == 0);
			end
			default: begin
				if (run_left == 0) begin
					stall_run = !stall_run;
					run_left  = stall_run ? $urandom_range(1, 16) : $urandom_range(1, 8);
				end
				run_left--;
				peak_stall <= stall_run;
			end
		endcase
	end

	// Guard against a block that hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// After reset the grid is one cell, so every value is a peak on its own.
	task automatic test_power_on_size();
		send_cell(32'sh8000_0000);
		send_cell(32'sh7FFF_FFFF);
		send_cell(32'sh0000_0000);
		send_cell(-32'sd1);
	endtask

	// A single row has left and right neighbours only.
	task automatic test_one_row();
		configure(6'd1, 6'd4);
		send_cell(32'sh8000_0000);
		send_cell(32'sh7FFF_FFFF);
		send_cell(32'sh7FFF_FFFF);
		send_cell(32'sh8000_0000);
	endtask

	// A single column has up and down neighbours only.
	task automatic test_one_column();
		configure(6'd4, 6'd1);
		send_cell(32'sd1);
		send_cell(32'sd5);
		send_cell(32'sd5);
		send_cell(-32'sd2);
	endtask

	// No peak in the final run, so a filler word closes the grid.
	task automatic test_peakless_run();
		configure(6'd2, 6'd2);
		send_cell(32'sd10);
		send_cell(32'sd5);
		send_cell(32'sd1);
		send_cell(32'sd2);
	endtask

	// A zero row count is taken as one.
	task automatic test_clamped_counts();
		configure(6'd0, 6'd3);
		send_cell(32'sd4);
		send_cell(32'sd4);
		send_cell(-32'sd7);
	endtask

	// A register write in the middle of a grid starts a new one.
	task automatic test_restart_on_write();
		configure(6'd2, 6'd2);
		send_cell(32'sd9);
		send_cell(32'sd3);
		settle();
		write_register(REG_COLUMN_COUNT, 6'd2);
		send_cell(-32'sd1);
		send_cell(32'sd6);
		send_cell(32'sd6);
		send_cell(32'sh8000_0000);
	endtask

	// Widest grid with ties everywhere gives the most words for one value; then the tallest grid.
	task automatic test_largest_counts();
		int k;
		configure(6'd2, 6'd63);
		sender_steady = 1'b1;
		for (k = 0; k < 2 * COLUMNS_MAX; k++) send_cell(-32'sd5);
		sender_steady = 1'b0;
		configure(6'd63, 6'd2);
		for (k = 0; k < 2 * ROWS_MAX; k++) send_cell(random_value(VALUES_MIXED));
	endtask

	// Random sizes and content, with the odd grid cut short by a new setting.
	task automatic test_random_grids();
		int                 sent, cells, grids, g, k, partial;
		value_mode_t        mode;
		logic [COUNT_W-1:0] rc, cc;
		sent = 0;
		while (sent < RANDOM_CELLS) begin
			do begin
				rc = random_count();
				cc = random_count();
			end while (effective_count(rc, ROWS_MAX) * effective_count(cc, COLUMNS_MAX)
				> MAX_CELLS);
			configure(rc, cc);
			cells = effective_count(rc, ROWS_MAX) * effective_count(cc, COLUMNS_MAX);
			grids = $urandom_range(1, 3);
			for (g = 0; g < grids; g++) begin
				mode          = value_mode_t'($urandom_range(0, 3));
				sender_steady = ($urandom_range(0, 3) == 0);
				for (k = 0; k < cells; k++) send_cell(random_value(mode));
				sent += cells;
			end
			sender_steady = 1'b0;
			if (cells > 1 && $urandom_range(0, 5) == 0) begin
				partial = $urandom_range(1, cells - 1);
				for (k = 0; k < partial; k++) send_cell(random_value(VALUES_FULL));
				sent += partial;
			end
		end
	endtask

	// Reset, the tests in turn, then the verdict.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_on_size();
		test_one_row();
		test_one_column();
		test_peakless_run();
		test_clamped_counts();
		test_restart_on_write();
		test_largest_counts();
		test_random_grids();
		settle();
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
